>>> src/pliu_pkg.sv
// ----------------------------------------------------------------------------
// pliu_pkg
// Shared types and constants for the polyline crossing unit.
// ----------------------------------------------------------------------------
package pliu_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int SEG_BITS       = 6;
  localparam int CTR_BITS       = 16;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_STREAM = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic rd_next;
    logic lat_p3;
    logic lat_p4;
    logic mul;
    logic sub;
    logic div_start;
    logic emit;
    logic step;
    logic flush;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_req;
    logic more;
    logic hit;
    logic div_busy;
    logic pend_valid;
    logic slot_free;
  } ctrl_sts_t;

endpackage

>>> src/pliu_div.sv
// ----------------------------------------------------------------------------
// pliu_div
// Two-lane bit-serial scaled divider: q = trunc(un * um / ud), one bit of um
// per cycle, both lanes sharing un and ud.
// ----------------------------------------------------------------------------
module pliu_div #(
  parameter int NW = 35,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] un,
  input  logic [NW-1:0] ud,
  input  logic [DW-1:0] umx,
  input  logic [DW-1:0] umy,
  output logic          busy,
  output logic [DW-1:0] qx,
  output logic [DW-1:0] qy
);

  localparam int RW   = NW + 1;
  localparam int CNTW = $clog2(DW);

  logic [NW-1:0]   un_r;
  logic [NW-1:0]   ud_r;
  logic [DW-1:0]   mx;
  logic [DW-1:0]   my;
  logic [RW-1:0]   rx;
  logic [RW-1:0]   ry;
  logic [CNTW-1:0] cnt;
  logic [RW+DW-1:0] nx;
  logic [RW+DW-1:0] ny;

  function automatic logic [RW+DW-1:0] div_step(logic [RW-1:0] r, logic [DW-1:0] q,
                                                 logic b, logic [NW-1:0] a_un,
                                                 logic [NW-1:0] a_ud);
    logic [RW-1:0] rr;
    logic [DW-1:0] qq;
    rr = {r[RW-2:0], 1'b0};
    qq = {q[DW-2:0], 1'b0};
    if (rr >= RW'(a_ud)) begin
      rr = rr - RW'(a_ud);
      qq = qq + DW'(1);
    end
    if (b) begin
      rr = rr + RW'(a_un);
      if (rr >= RW'(a_ud)) begin
        rr = rr - RW'(a_ud);
        qq = qq + DW'(1);
      end
    end
    return {rr, qq};
  endfunction

  assign nx = div_step(rx, qx, mx[DW-1], un_r, ud_r);
  assign ny = div_step(ry, qy, my[DW-1], un_r, ud_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(DW - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end
      cnt <= cnt - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      un_r <= un;
      ud_r <= ud;
      mx   <= umx;
      my   <= umy;
      rx   <= '0;
      ry   <= '0;
      qx   <= '0;
      qy   <= '0;
    end else if (busy) begin
      mx <= {mx[DW-2:0], 1'b0};
      my <= {my[DW-2:0], 1'b0};
      rx <= nx[RW+DW-1:DW];
      qx <= nx[DW-1:0];
      ry <= ny[RW+DW-1:DW];
      qy <= ny[DW-1:0];
    end
  end

endmodule

>>> src/pliu_ctrl.sv
// ----------------------------------------------------------------------------
// pliu_ctrl
// Sequencer: accepts items, walks the stored segments, runs the divider and
// hands crossings to the output stage.
// ----------------------------------------------------------------------------
module pliu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pliu_pkg::ctrl_sts_t sts,
  output pliu_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_BEGIN, S_RDA, S_RDB, S_MUL, S_SUB, S_TEST, S_DIV, S_EMIT, S_STEP, S_FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.walk_req) begin
            state_next = S_BEGIN;
          end
        end
      end
      S_BEGIN: state_next = sts.more ? S_RDA : S_FLUSH;
      S_RDA: begin
        cmd.lat_p3  = 1'b1;
        cmd.rd_next = 1'b1;
        state_next  = S_RDB;
      end
      S_RDB: begin
        cmd.lat_p4 = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SUB;
      end
      S_SUB: begin
        cmd.sub    = 1'b1;
        state_next = S_TEST;
      end
      S_TEST: begin
        if (sts.hit) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_STEP;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!sts.pend_valid || sts.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = S_BEGIN;
      end
      S_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = S_IDLE;
        end else if (sts.slot_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> src/pliu_dp.sv
// ----------------------------------------------------------------------------
// pliu_dp
// Datapath: point store, streamed path state, cross products, crossing test,
// result hold stage and output register.
// ----------------------------------------------------------------------------
module pliu_dp #(
  parameter int MAX_POINTS = pliu_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = pliu_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic                               cfg_data,
  input  logic [1:0]                         command,
  input  logic signed [COORD_BITS-1:0]       x_coord,
  input  logic signed [COORD_BITS-1:0]       y_coord,
  input  logic                               first_point,
  input  logic                               out_ready,
  input  pliu_pkg::ctrl_cmd_t                cmd,
  output pliu_pkg::ctrl_sts_t                sts,
  output logic                               out_valid,
  output logic signed [COORD_BITS-1:0]       cross_x,
  output logic signed [COORD_BITS-1:0]       cross_y,
  output logic [pliu_pkg::SEG_BITS-1:0]      stored_segment,
  output logic [pliu_pkg::CTR_BITS-1:0]      streamed_segment,
  output logic                               last_result
);

  localparam int C    = COORD_BITS;
  localparam int DW   = C + 1;
  localparam int PW   = 2 * DW;
  localparam int NW   = PW + 1;
  localparam int IDXW = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int CTRW = pliu_pkg::CTR_BITS;
  localparam int JW   = CTRW + 2;
  localparam int SEGW = pliu_pkg::SEG_BITS;

  // point store
  logic [2*C-1:0] mem [MAX_POINTS];
  logic [2*C-1:0] rdata;
  logic [IDXW-1:0] rd_addr;

  logic [CW-1:0]   count;
  logic            self_mode;
  logic signed [C-1:0] prev_x, prev_y;
  logic            have_prev;
  logic [CTRW-1:0] seg_ctr;
  logic [CTRW-1:0] seg_cur;

  logic signed [C-1:0]  x1, y1, p3x, p3y, p4x, p4y;
  logic signed [DW-1:0] dx, dy;
  logic [IDXW-1:0]      j;
  logic                 j_ok;

  logic signed [DW-1:0] ex, ey, wx, wy;
  logic signed [PW-1:0] pa, pb, pc, pd, pe, pf;
  logic signed [NW-1:0] delta, ns, nt;

  logic                 neg_x, neg_y;
  logic [DW-1:0]        qx, qy;
  logic                 div_busy;
  logic signed [DW-1:0] res_x, res_y;

  logic                 pnd_valid;
  logic signed [C-1:0]  pnd_x, pnd_y;
  logic [SEGW-1:0]      pnd_j;
  logic [CTRW-1:0]      pnd_seg;
  logic                 out_load;

  logic [JW-1:0]        jst;

  function automatic logic in_unit(logic signed [NW-1:0] num, logic signed [NW-1:0] den);
    if (den > 0) begin
      return (num >= 0) && (num <= den);
    end
    return (num <= 0) && (num >= den);
  endfunction

  function automatic logic [NW-1:0] mag(logic signed [NW-1:0] v);
    return v[NW-1] ? NW'(-v) : NW'(v);
  endfunction

  assign sts.walk_req   = (command == pliu_pkg::CMD_STREAM) && !first_point && have_prev;
  assign sts.more       = j_ok && ((CW + 1)'(j) + (CW + 1)'(1) < (CW + 1)'(count));
  assign sts.hit        = (delta != '0) && in_unit(ns, delta) && in_unit(nt, delta);
  assign sts.div_busy   = div_busy;
  assign sts.pend_valid = pnd_valid;
  assign sts.slot_free  = !out_valid || out_ready;

  assign jst     = self_mode ? (JW'(seg_ctr) + JW'(2)) : '0;
  assign rd_addr = cmd.rd_next ? (j + IDXW'(1)) : j;

  assign ex = DW'(p3x) - DW'(p4x);
  assign ey = DW'(p3y) - DW'(p4y);
  assign wx = DW'(p3x) - DW'(x1);
  assign wy = DW'(p3y) - DW'(y1);

  // crossing point: the streamed start plus a signed offset
  assign res_x = DW'(x1) + (neg_x ? -$signed(qx) : $signed(qx));
  assign res_y = DW'(y1) + (neg_y ? -$signed(qy) : $signed(qy));

  always_ff @(posedge clk) begin
    if (cmd.accept && (command == pliu_pkg::CMD_APPEND) && (count < CW'(MAX_POINTS))) begin
      mem[count[IDXW-1:0]] <= {x_coord, y_coord};
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      self_mode <= 1'b0;
    end else if (cfg_we) begin
      self_mode <= cfg_data;
    end
  end

  // item handling and walk index
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      prev_x    <= '0;
      prev_y    <= '0;
      have_prev <= 1'b0;
      seg_ctr   <= '0;
      j_ok      <= 1'b0;
    end else if (cmd.accept) begin
      case (command)
        pliu_pkg::CMD_CLEAR: count <= '0;
        pliu_pkg::CMD_APPEND: begin
          if (count < CW'(MAX_POINTS)) begin
            count <= count + CW'(1);
          end
        end
        pliu_pkg::CMD_STREAM: begin
          prev_x    <= x_coord;
          prev_y    <= y_coord;
          have_prev <= 1'b1;
          if (first_point || !have_prev) begin
            seg_ctr <= '0;
          end else begin
            if (seg_ctr != '1) begin
              seg_ctr <= seg_ctr + CTRW'(1);
            end
            j_ok <= (jst + JW'(1)) < JW'(count);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x1      <= prev_x;
      y1      <= prev_y;
      dx      <= DW'(x_coord) - DW'(prev_x);
      dy      <= DW'(y_coord) - DW'(prev_y);
      seg_cur <= seg_ctr;
      j       <= IDXW'(jst);
    end else if (cmd.step) begin
      j <= j + IDXW'(1);
    end
    if (cmd.lat_p3) begin
      p3x <= rdata[2*C-1:C];
      p3y <= rdata[C-1:0];
    end
    if (cmd.lat_p4) begin
      p4x <= rdata[2*C-1:C];
      p4y <= rdata[C-1:0];
    end
    if (cmd.mul) begin
      pa <= dx * ey;
      pb <= dy * ex;
      pc <= wx * ey;
      pd <= wy * ex;
      pe <= dx * wy;
      pf <= dy * wx;
    end
    if (cmd.sub) begin
      delta <= NW'(pa) - NW'(pb);
      ns    <= NW'(pc) - NW'(pd);
      nt    <= NW'(pe) - NW'(pf);
    end
    if (cmd.div_start) begin
      neg_x <= ns[NW-1] ^ dx[DW-1] ^ delta[NW-1];
      neg_y <= ns[NW-1] ^ dy[DW-1] ^ delta[NW-1];
    end
  end

  pliu_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .un   (mag(ns)),
    .ud   (mag(delta)),
    .umx  (dx[DW-1] ? DW'(-dx) : DW'(dx)),
    .umy  (dy[DW-1] ? DW'(-dy) : DW'(dy)),
    .busy (div_busy),
    .qx   (qx),
    .qy   (qy)
  );

  // a crossing waits in the hold stage until the next one shows whether it was last
  assign out_load = (cmd.emit && pnd_valid) || cmd.flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      pnd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        pnd_valid <= 1'b1;
      end else if (cmd.flush) begin
        pnd_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pnd_x   <= res_x[C-1:0];
      pnd_y   <= res_y[C-1:0];
      pnd_j   <= SEGW'(j);
      pnd_seg <= seg_cur;
    end
    if (out_load) begin
      cross_x          <= pnd_x;
      cross_y          <= pnd_y;
      stored_segment   <= pnd_j;
      streamed_segment <= pnd_seg;
      last_result      <= cmd.flush;
    end
  end

endmodule

>>> src/polyline_intersection_points_unit.sv
// ----------------------------------------------------------------------------
// polyline_intersection_points_unit
// Stores a reference polyline and reports crossings of a streamed
// polyline with it, tested by integer cross products.
// ----------------------------------------------------------------------------
//  channel   signals                                            direction
//  in        in_valid/in_ready, command, x_coord, y_coord,      to block
//            first_point
//  out       out_valid/out_ready, cross_x, cross_y,             from block
//            stored_segment, streamed_segment, last_result
//  cfg       cfg_valid/cfg_ready, cfg_data (self_mode)          to block
//
//  clear, append and path-start beats are accepted without a walk.
//  a streamed segment walks the stored segments in turn (read, multiply,
//  subtract, test) and runs the bit-serial divider for each crossing found.
//  the final crossing of a beat is held until the walk ends, so last_result
//  is known; a stalled output holds the walk at the next crossing.
//  rst is synchronous and clears the stored count, path state and self_mode.
// ----------------------------------------------------------------------------
module polyline_intersection_points_unit #(
  parameter int MAX_POINTS = pliu_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = pliu_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    command,
  input  logic signed [COORD_BITS-1:0]  x_coord,
  input  logic signed [COORD_BITS-1:0]  y_coord,
  input  logic                          first_point,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_BITS-1:0]  cross_x,
  output logic signed [COORD_BITS-1:0]  cross_y,
  output logic [pliu_pkg::SEG_BITS-1:0] stored_segment,
  output logic [pliu_pkg::CTR_BITS-1:0] streamed_segment,
  output logic                          last_result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data
);

  pliu_pkg::ctrl_cmd_t cmd;
  pliu_pkg::ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  pliu_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  pliu_dp #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_valid),
    .cfg_data        (cfg_data),
    .command         (command),
    .x_coord         (x_coord),
    .y_coord         (y_coord),
    .first_point     (first_point),
    .out_ready       (out_ready),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .cross_x         (cross_x),
    .cross_y         (cross_y),
    .stored_segment  (stored_segment),
    .streamed_segment(streamed_segment),
    .last_result     (last_result)
  );

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for polyline_intersection_points_unit. A stored path is
// loaded and a second path streamed through it. A local model of the crossing
// arithmetic predicts every result beat, and a checker compares each one in
// order. Random gaps and stalls appear on both channels, along with one long
// output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  NPTS       = pliu_pkg::MAX_POINTS_DEF;
  localparam int  CYCLE_CAP  = 4000000;
  localparam int  WALK_DRAIN = 1500;
  localparam int  HOLD_LEN   = 3000;
  localparam int  CTR_MAX    = 65535;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [5:0]         seg;
    logic [15:0]        sseg;
    logic               last;
  } crossing_t;

  logic clk, rst;
  logic in_valid, in_ready, first_point;
  logic [1:0] command;
  logic signed [15:0] x_coord, y_coord;
  logic out_valid, out_ready, last_result;
  logic signed [15:0] cross_x, cross_y;
  logic [5:0] stored_segment;
  logic [15:0] streamed_segment;
  logic cfg_valid, cfg_ready, cfg_data;

  polyline_intersection_points_unit dut (
    .clk, .rst, .in_valid, .in_ready, .command, .x_coord, .y_coord, .first_point,
    .out_valid, .out_ready, .cross_x, .cross_y, .stored_segment, .streamed_segment,
    .last_result, .cfg_valid, .cfg_ready, .cfg_data
  );

  // model state
  logic signed [15:0] path_x [NPTS];
  logic signed [15:0] path_y [NPTS];
  int                 path_len;
  logic signed [15:0] prev_x, prev_y;
  bit                 prev_ok;
  int                 seg_ctr;
  bit                 self_cfg;

  crossing_t pending_crossings[$];
  int  mismatches, beats_sent, crossings_seen, cycles;
  bit  quiet_in, quiet_out, hold_req;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d crossings pending", cycles,
               pending_crossings.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 20) $display("%0t: %s", $realtime, what);
  endtask

  function automatic bit in_unit(input longint n, input longint d);
    return d > 0 ? (n >= 0 && n <= d) : (n <= 0 && n >= d);
  endfunction

  task automatic predict_beat(input pliu_pkg::cmd_t cmd, input logic signed [15:0] x,
                              input logic signed [15:0] y, input bit first);
    longint dx, dy, ex, ey, wx, wy, delta, ns, nt;
    int j, jlo, nfound;
    crossing_t c;
    nfound = 0;
    case (cmd)
      pliu_pkg::CMD_CLEAR: path_len = 0;
      pliu_pkg::CMD_APPEND: begin
        if (path_len < NPTS) begin
          path_x[path_len] = x;
          path_y[path_len] = y;
          path_len++;
        end
      end
      pliu_pkg::CMD_STREAM: begin
        if (first || !prev_ok) begin
          prev_ok = 1'b1;
          seg_ctr = 0;
        end else begin
          dx = longint'(x) - prev_x;
          dy = longint'(y) - prev_y;
          jlo = self_cfg ? seg_ctr + 2 : 0;
          for (j = jlo; j + 1 < path_len; j++) begin
            ex = longint'(path_x[j]) - path_x[j+1];
            ey = longint'(path_y[j]) - path_y[j+1];
            wx = longint'(path_x[j]) - prev_x;
            wy = longint'(path_y[j]) - prev_y;
            delta = dx * ey - dy * ex;
            if (delta == 0) continue;
            ns = wx * ey - wy * ex;
            nt = dx * wy - dy * wx;
            if (!in_unit(ns, delta) || !in_unit(nt, delta)) continue;
            c.cx   = 16'(prev_x + (ns * dx) / delta);
            c.cy   = 16'(prev_y + (ns * dy) / delta);
            c.seg  = 6'(j);
            c.sseg = 16'(seg_ctr);
            c.last = 1'b0;
            pending_crossings.insert(pending_crossings.size(), c);
            nfound++;
          end
          if (nfound > 0) pending_crossings[$].last = 1'b1;
          if (seg_ctr < CTR_MAX) seg_ctr++;
        end
        prev_x = x;
        prev_y = y;
      end
      default: ;
    endcase
  endtask

  // one input beat; valid stays up into the next beat when no gap is drawn
  task automatic send_beat(input pliu_pkg::cmd_t cmd, input logic signed [15:0] x,
                           input logic signed [15:0] y, input bit first);
    int gap;
    in_valid    <= 1'b1;
    command     <= cmd;
    x_coord     <= x;
    y_coord     <= y;
    first_point <= first;
    do @(posedge clk); while (!in_ready);
    predict_beat(cmd, x, y, first);
    beats_sent++;
    gap = quiet_in ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_crossings.size() != 0) @(posedge clk);
    repeat (WALK_DRAIN) @(posedge clk);
  endtask

  task automatic write_self_mode(input bit v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    self_cfg = v;
  endtask

  function automatic logic signed [15:0] pick_coord(input int span);
    if (span == 0) return 16'($urandom);
    return 16'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic load_path(input int n, input int span);
    send_beat(pliu_pkg::CMD_CLEAR, pick_coord(0), pick_coord(0), $urandom_range(0, 1));
    repeat (n) send_beat(pliu_pkg::CMD_APPEND, pick_coord(span), pick_coord(span),
                         $urandom_range(0, 1));
  endtask

  task automatic stream_path(input int n, input int span);
    send_beat(pliu_pkg::CMD_STREAM, pick_coord(span), pick_coord(span), 1'b1);
    repeat (n - 1) send_beat(pliu_pkg::CMD_STREAM, pick_coord(span), pick_coord(span), 1'b0);
  endtask

  // result checker
  initial begin
    crossing_t got, want;
    int stall;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        stall = quiet_out ? 0 : $urandom_range(0, 17);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      crossings_seen++;
      got = '{cross_x, cross_y, stored_segment, streamed_segment, last_result};
      if (pending_crossings.size() == 0) begin
        report($sformatf("unexpected crossing beat %p", got));
      end else begin
        want = pending_crossings.pop_front();
        if (got.cx !== want.cx)
          report($sformatf("cross_x %0d, want %0d", got.cx, want.cx));
        if (got.cy !== want.cy)
          report($sformatf("cross_y %0d, want %0d", got.cy, want.cy));
        if (got.seg !== want.seg)
          report($sformatf("stored_segment %0d, want %0d", got.seg, want.seg));
        if (got.sseg !== want.sseg)
          report($sformatf("streamed_segment %0d, want %0d", got.sseg, want.sseg));
        if (got.last !== want.last)
          report($sformatf("last_result %0b, want %0b", got.last, want.last));
      end
    end
  end

  task automatic test_directed();
    send_beat(pliu_pkg::CMD_STREAM, 16'sd5, 16'sd5, 1'b0);          // no previous point yet
    send_beat(pliu_pkg::CMD_STREAM, 16'sd9, 16'sd9, 1'b0);          // no stored segments
    send_beat(pliu_pkg::CMD_APPEND, -16'sd32768, -16'sd32768, 1'b0);
    send_beat(pliu_pkg::CMD_STREAM, 16'sd1, -16'sd1, 1'b0);         // one stored point only
    send_beat(pliu_pkg::CMD_APPEND, 16'sd32767, 16'sd32767, 1'b1);
    send_beat(pliu_pkg::CMD_APPEND, 16'sd32767, -16'sd32768, 1'b0);
    send_beat(pliu_pkg::CMD_NOP, -16'sd1, -16'sd1, 1'b1);
    send_beat(pliu_pkg::CMD_STREAM, -16'sd32768, 16'sd32767, 1'b1);
    send_beat(pliu_pkg::CMD_STREAM, 16'sd32767, -16'sd32768, 1'b0); // corner to corner
    send_beat(pliu_pkg::CMD_STREAM, 16'sd32767, 16'sd0, 1'b0);      // collinear with a side
    send_beat(pliu_pkg::CMD_STREAM, -16'sd100, -16'sd100, 1'b0);
    send_beat(pliu_pkg::CMD_STREAM, 16'sd100, 16'sd100, 1'b0);      // parallel, on the diagonal
    send_beat(pliu_pkg::CMD_STREAM, 16'sd0, 16'sd0, 1'b1);
    send_beat(pliu_pkg::CMD_STREAM, 16'sd32767, 16'sd0, 1'b0);      // ends on a stored side
    send_beat(pliu_pkg::CMD_CLEAR, 16'sd0, 16'sd0, 1'b0);
    send_beat(pliu_pkg::CMD_APPEND, 16'sd10, -16'sd10, 1'b0);
    send_beat(pliu_pkg::CMD_APPEND, 16'sd10, 16'sd10, 1'b0);
    send_beat(pliu_pkg::CMD_STREAM, 16'sd20, -16'sd3, 1'b0);        // clear kept the path
    send_beat(pliu_pkg::CMD_STREAM, -16'sd7, 16'sd1, 1'b0);
    send_beat(pliu_pkg::CMD_STREAM, 16'sd7, 16'sd3, 1'b0);
  endtask

  task automatic test_store_full();
    load_path(NPTS + 2, 40);                              // last appends are dropped
    stream_path(6, 40);
  endtask

  task automatic test_self_mode();
    logic signed [15:0] px [12];
    logic signed [15:0] py [12];
    int k;
    write_self_mode(1'b1);
    send_beat(pliu_pkg::CMD_CLEAR, 16'sd0, 16'sd0, 1'b0);
    for (k = 0; k < 12; k++) begin
      px[k] = pick_coord(30);
      py[k] = pick_coord(30);
      send_beat(pliu_pkg::CMD_APPEND, px[k], py[k], 1'b0);
    end
    for (k = 0; k < 12; k++) send_beat(pliu_pkg::CMD_STREAM, px[k], py[k], k == 0);
    write_self_mode(1'b0);
  endtask

  task automatic test_random();
    int k, n;
    bit sm;
    for (k = 0; k < 5; k++) begin
      if (k % 4 == 2) begin
        sm = $urandom_range(0, 1);
        write_self_mode(sm);
      end
      quiet_in  = (k % 5 == 3);
      quiet_out = (k % 5 == 3);
      n = ($urandom_range(0, 9) == 0) ? NPTS : $urandom_range(2, 10);
      load_path(n, (k % 3 == 0) ? 0 : 25);
      stream_path($urandom_range(3, 10), (k % 3 == 1) ? 0 : 25);
      // noise: any command, any start flag
      send_beat(pliu_pkg::cmd_t'($urandom_range(0, 3)), pick_coord(0), pick_coord(0),
                $urandom_range(0, 1));
      send_beat(pliu_pkg::CMD_STREAM, pick_coord(25), pick_coord(25), $urandom_range(0, 1));
    end
    quiet_in  = 1'b0;
    quiet_out = 1'b0;
    write_self_mode(1'b0);
  endtask

  task automatic test_backpressure();
    load_path(24, 12);
    hold_req = 1'b1;
    quiet_in = 1'b1;
    stream_path(10, 12);
    quiet_in = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = pliu_pkg::CMD_NOP;
    x_coord = '0;
    y_coord = '0;
    first_point = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    path_len = 0;
    prev_x = '0;
    prev_y = '0;
    prev_ok = 1'b0;
    seg_ctr = 0;
    self_cfg = 1'b0;
    mismatches = 0;
    beats_sent = 0;
    crossings_seen = 0;
    cycles = 0;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    hold_req = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_store_full();
    test_self_mode();
    test_random();
    test_backpressure();

    wait_drained();
    $display("sent %0d input beats, checked %0d crossing beats", beats_sent, crossings_seen);
    $display("covered: full store, self mode on and off, clear keeping the path, long hold-off");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
